>>> hdl/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

   // field widths
   localparam int VAL_W   = 32;
   localparam int POS_W   = 4;
   localparam int SIZE_W  = 5;
   localparam int COORD_W = 5;
   localparam int SCL_W   = 32;

   // request word layout, lowest bit first
   localparam int POS_X_LSB   = 0;
   localparam int POS_Y_LSB   = POS_X_LSB + POS_W;
   localparam int POS_Z_LSB   = POS_Y_LSB + POS_W;
   localparam int COMP_X_LSB  = POS_Z_LSB + POS_W;
   localparam int COMP_Y_LSB  = COMP_X_LSB + VAL_W;
   localparam int COMP_Z_LSB  = COMP_Y_LSB + VAL_W;
   localparam int REQ_USED_W  = COMP_Z_LSB + VAL_W;
   localparam int REQ_DATA_W  = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 4 * VAL_W;

   // config port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_X    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Y    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_Z    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TWO_H = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET      = 5'd16;
   localparam logic [SCL_W-1:0]  INV_TWO_H_RESET = 32'd32768;
   localparam logic [SIZE_W-1:0] MIN_SIZE        = 5'd3;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // axis codes, also the stencil pass order
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // stencil taps
   localparam logic [1:0] TAP_0 = 2'd0;
   localparam logic [1:0] TAP_1 = 2'd1;
   localparam logic [1:0] TAP_2 = 2'd2;

   // arithmetic widths
   localparam int DIFF_W  = VAL_W + 4;        // raw difference, |D| <= 2^34
   localparam int MAG_W   = DIFF_W - 1;
   localparam int HALF_W  = SCL_W / 2;
   localparam int PROD_W  = MAG_W + HALF_W;
   localparam int SCALE_W = PROD_W + 2;       // signed scaled derivative
   localparam int ACC_W   = SCALE_W + 2;      // sum of three derivatives

   // result slots
   localparam int RES_CURL_X = 0;
   localparam int RES_CURL_Y = 1;
   localparam int RES_CURL_Z = 2;
   localparam int RES_DIV    = 3;

   typedef enum logic [1:0] {
      REG_LOW,    // first point on the axis: one-sided forward stencil
      REG_MID,    // interior: central difference
      REG_HIGH    // last point on the axis: one-sided backward stencil
   } region_type;

   function automatic logic [VAL_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-VAL_W:0] top;
      top = v[ACC_W-1:VAL_W-1];
      if ((&top) || (~|top)) begin
         return v[VAL_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VAL_W-1){1'b1}}};
      end
   endfunction

endpackage

>>> hdl/grid_curl_divergence_top.sv
`timescale 1ns / 1ps

// Curl and divergence of a 3-D vector field held on a grid.
// req channel: one word per item. tuser = kind (load or query). A load writes
//   the three Q16.16 components of one grid point and is done in the cycle it
//   is accepted; it produces no rsp word. Loads beyond MAX_* are dropped.
// rsp channel: one word per query holding curl x/y/z and divergence,
//   each signed Q16.16 saturated to 32 bits.
// csr channel: always ready; index 0..2 = grid sizes in use, 3 = 1/(2h) as
//   unsigned Q16.16. Write only while the block is idle.
// Loads are taken one per cycle while no query is in flight. A query holds
//   req_tready low from acceptance until rsp_tvalid is set, and req_tready comes
//   back in that same cycle. The query time is set by the one read port of the
//   field RAM: the nine stencil points (three per axis) are read one per cycle,
//   then the difference, a two-stage scaling multiply and the accumulate follow.
// The finished result sits in an output register, so the next item is taken
//   while rsp waits; a further query stops in its hand-off step until rsp_tready.
// Reset clears control state and restores the reset register values; the
//   field RAM is not cleared, and a query must only touch loaded points.
module grid_curl_divergence_top #(
   parameter int MAX_X = 16,
   parameter int MAX_Y = 16,
   parameter int MAX_Z = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x[3:0], pos_y[7:4], pos_z[11:8], comp_x[43:12], comp_y[75:44],
   // comp_z[107:76], zero fill up to 112 bits
   input  logic [gcd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind
   input  logic [gcd_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // curl_x[31:0], curl_y[63:32], curl_z[95:64], divergence[127:96]
   output logic [gcd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gcd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gcd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import gcd_pkg::*;

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = $clog2(DEPTH);
   localparam int WORD_W = 3 * VAL_W;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_HAND} state_type;

   function automatic logic [COORD_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                   input int mx);
      if (s < MIN_SIZE) begin
         return MIN_SIZE;
      end else if (int'(s) > mx) begin
         return COORD_W'(mx);
      end else begin
         return s;
      end
   endfunction

   function automatic logic [AW-1:0] point_addr(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [COORD_W-1:0] c);
      int lin;
      lin = (int'(a) * MAX_Y + int'(b)) * MAX_Z + int'(c);
      return lin[AW-1:0];
   endfunction

   // ---------------- config registers ----------------
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SCL_W-1:0]  inv_two_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= SIZE_RESET;
         size_y_ff    <= SIZE_RESET;
         size_z_ff    <= SIZE_RESET;
         inv_two_h_ff <= INV_TWO_H_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIZE_X:    size_x_ff    <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Y:    size_y_ff    <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Z:    size_z_ff    <= csr_data[SIZE_W-1:0];
            CSR_INV_TWO_H: inv_two_h_ff <= csr_data[SCL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- request decode ----------------
   state_type state_ff;
   logic      req_acc, load_go, query_go;
   logic [POS_W-1:0]   pos_in [3];
   logic [COORD_W-1:0] nsize_in [3];
   logic [COORD_W-1:0] pt_in [3];
   region_type         region_in [3];
   logic               pos_ok;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign pos_in[0] = req_tdata[POS_X_LSB +: POS_W];
   assign pos_in[1] = req_tdata[POS_Y_LSB +: POS_W];
   assign pos_in[2] = req_tdata[POS_Z_LSB +: POS_W];

   assign nsize_in[0] = eff_size(size_x_ff, MAX_X);
   assign nsize_in[1] = eff_size(size_y_ff, MAX_Y);
   assign nsize_in[2] = eff_size(size_z_ff, MAX_Z);

   assign pos_ok = (int'(pos_in[0]) < MAX_X) && (int'(pos_in[1]) < MAX_Y) &&
                   (int'(pos_in[2]) < MAX_Z);

   assign load_go  = req_acc && (req_tuser[0] == KIND_LOAD) && pos_ok;
   assign query_go = req_acc && (req_tuser[0] == KIND_QUERY);

   // clamp the query point into the grid in use and classify it per axis
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (COORD_W'(pos_in[a]) >= nsize_in[a]) begin
            pt_in[a] = nsize_in[a] - COORD_W'(1);
         end else begin
            pt_in[a] = COORD_W'(pos_in[a]);
         end
         if (pt_in[a] == '0) begin
            region_in[a] = REG_LOW;
         end else if (pt_in[a] + COORD_W'(1) >= nsize_in[a]) begin
            region_in[a] = REG_HIGH;
         end else begin
            region_in[a] = REG_MID;
         end
      end
   end

   logic [COORD_W-1:0] pt_ff [3];
   logic [COORD_W-1:0] nsize_ff [3];
   region_type         region_ff [3];

   always_ff @(posedge clock) begin
      if (query_go) begin
         pt_ff     <= pt_in;
         nsize_ff  <= nsize_in;
         region_ff <= region_in;
      end
   end

   // ---------------- stencil address ----------------
   logic [1:0]         axis_ff, tap_ff;
   logic [COORD_W-1:0] nb;
   logic [COORD_W-1:0] rd_pt [3];
   logic [AW-1:0]      rd_addr, wr_addr;

   always_comb begin
      case (region_ff[axis_ff])
         REG_LOW:  nb = COORD_W'(tap_ff);
         REG_HIGH: nb = nsize_ff[axis_ff] - COORD_W'(1) - COORD_W'(tap_ff);
         default: begin
            case (tap_ff)
               TAP_0:   nb = pt_ff[axis_ff] + COORD_W'(1);
               TAP_1:   nb = pt_ff[axis_ff] - COORD_W'(1);
               default: nb = pt_ff[axis_ff];
            endcase
         end
      endcase
      rd_pt = pt_ff;
      rd_pt[axis_ff] = nb;
   end

   assign rd_addr = point_addr(rd_pt[0], rd_pt[1], rd_pt[2]);
   assign wr_addr = point_addr(COORD_W'(pos_in[0]), COORD_W'(pos_in[1]),
                               COORD_W'(pos_in[2]));

   // ---------------- field RAM: one word = three components ----------------
   logic [WORD_W-1:0] field_ram_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (load_go) begin
         field_ram_ff[wr_addr] <= req_tdata[COMP_X_LSB +: WORD_W];
      end
      rd_data_ff <= field_ram_ff[rd_addr];
   end

   // ---------------- difference accumulate ----------------
   logic       rv_ff;
   logic [1:0] raxis_ff, rtap_ff;
   logic signed [DIFF_W-1:0] dacc_ff [3];
   logic signed [DIFF_W-1:0] dacc_in [3];
   logic       dq_valid_ff;
   logic [1:0] dq_axis_ff;

   always_comb begin
      logic signed [DIFF_W-1:0] v, v3, v4, t_low, term;
      for (int c = 0; c < 3; c++) begin
         v  = DIFF_W'($signed(rd_data_ff[c*VAL_W +: VAL_W]));
         v3 = (v <<< 1) + v;
         v4 = v <<< 2;
         case (rtap_ff)
            TAP_0:   t_low = -v3;
            TAP_1:   t_low = v4;
            default: t_low = -v;
         endcase
         case (region_ff[raxis_ff])
            REG_LOW:  term = t_low;
            REG_HIGH: term = -t_low;
            default: begin
               case (rtap_ff)
                  TAP_0:   term = v;
                  TAP_1:   term = -v;
                  default: term = '0;
               endcase
            end
         endcase
         dacc_in[c] = ((rtap_ff == TAP_0) ? DIFF_W'(0) : dacc_ff[c]) + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff       <= 1'b0;
         dq_valid_ff <= 1'b0;
      end else begin
         rv_ff       <= (state_ff == S_READ);
         dq_valid_ff <= rv_ff && (rtap_ff == TAP_2);
      end
      raxis_ff   <= axis_ff;
      rtap_ff    <= tap_ff;
      dq_axis_ff <= raxis_ff;
      if (rv_ff) begin
         dacc_ff <= dacc_in;
      end
   end

   // ---------------- scaling: (|D| * inv_two_h + 2^15) >> 16 ----------------
   logic              sa_valid_ff;
   logic [1:0]        sa_axis_ff;
   logic              sa_neg_ff [3];
   logic [PROD_W-1:0] sa_lo_ff [3];
   logic [PROD_W-1:0] sa_hi_ff [3];

   always_ff @(posedge clock) begin
      logic [DIFF_W-1:0] mag;
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= dq_valid_ff;
      end
      sa_axis_ff <= dq_axis_ff;
      for (int c = 0; c < 3; c++) begin
         mag = dacc_ff[c][DIFF_W-1] ? DIFF_W'(-dacc_ff[c]) : DIFF_W'(dacc_ff[c]);
         sa_neg_ff[c] <= dacc_ff[c][DIFF_W-1];
         sa_lo_ff[c]  <= PROD_W'(mag[MAG_W-1:0]) * PROD_W'(inv_two_h_ff[HALF_W-1:0]);
         sa_hi_ff[c]  <= PROD_W'(mag[MAG_W-1:0]) * PROD_W'(inv_two_h_ff[SCL_W-1:HALF_W]);
      end
   end

   logic                      sb_valid_ff;
   logic [1:0]                sb_axis_ff;
   logic signed [SCALE_W-1:0] sc_ff [3];

   always_ff @(posedge clock) begin
      logic [PROD_W:0] rnd, q;
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else begin
         sb_valid_ff <= sa_valid_ff;
      end
      sb_axis_ff <= sa_axis_ff;
      for (int c = 0; c < 3; c++) begin
         rnd = {1'b0, sa_lo_ff[c]} + (PROD_W + 1)'(1 << (HALF_W - 1));
         q   = {1'b0, sa_hi_ff[c]} + (rnd >> HALF_W);
         sc_ff[c] <= sa_neg_ff[c] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
   end

   // ---------------- curl / divergence accumulate ----------------
   logic signed [ACC_W-1:0] acc_ff [4];
   logic signed [ACC_W-1:0] acc_in [4];
   logic signed [ACC_W-1:0] s0, s1, s2;

   assign s0 = ACC_W'(sc_ff[0]);
   assign s1 = ACC_W'(sc_ff[1]);
   assign s2 = ACC_W'(sc_ff[2]);

   always_comb begin
      acc_in = acc_ff;
      case (sb_axis_ff)
         AXIS_X: begin          // dFx/dx, dFy/dx, dFz/dx
            acc_in[RES_DIV]    = acc_ff[RES_DIV] + s0;
            acc_in[RES_CURL_Z] = acc_ff[RES_CURL_Z] + s1;
            acc_in[RES_CURL_Y] = acc_ff[RES_CURL_Y] - s2;
         end
         AXIS_Y: begin          // dFx/dy, dFy/dy, dFz/dy
            acc_in[RES_CURL_Z] = acc_ff[RES_CURL_Z] - s0;
            acc_in[RES_DIV]    = acc_ff[RES_DIV] + s1;
            acc_in[RES_CURL_X] = acc_ff[RES_CURL_X] + s2;
         end
         default: begin         // dFx/dz, dFy/dz, dFz/dz
            acc_in[RES_CURL_Y] = acc_ff[RES_CURL_Y] + s0;
            acc_in[RES_CURL_X] = acc_ff[RES_CURL_X] - s1;
            acc_in[RES_DIV]    = acc_ff[RES_DIV] + s2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (query_go) begin
         for (int r = 0; r < 4; r++) begin
            acc_ff[r] <= '0;
         end
      end else if (sb_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------- sequencer and output register ----------------
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         axis_ff       <= AXIS_X;
         tap_ff        <= TAP_0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // the hand-off step reloads the output register itself
         if (rsp_tready && (state_ff != S_HAND)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               axis_ff <= AXIS_X;
               tap_ff  <= TAP_0;
               if (query_go) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (tap_ff == TAP_2) begin
                  tap_ff <= TAP_0;
                  if (axis_ff == AXIS_Z) begin
                     state_ff <= S_WAIT;
                  end else begin
                     axis_ff <= axis_ff + 2'd1;
                  end
               end else begin
                  tap_ff <= tap_ff + 2'd1;
               end
            end
            S_WAIT: begin
               // last axis lands in the accumulators at this edge
               if (sb_valid_ff && (sb_axis_ff == AXIS_Z)) begin
                  state_ff <= S_HAND;
               end
            end
            S_HAND: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {sat_word(acc_ff[RES_DIV]),
                                    sat_word(acc_ff[RES_CURL_Z]),
                                    sat_word(acc_ff[RES_CURL_Y]),
                                    sat_word(acc_ff[RES_CURL_X])};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> tb/sv/grid_curl_divergence_top_tb.sv
`timescale 1ns / 1ps

module grid_curl_divergence_top_tb;
   import gcd_pkg::*;

   localparam int GRID_N      = 16;
   localparam int GRID_DEPTH  = GRID_N * GRID_N * GRID_N;
   localparam int HOLD_CYCLES = 400;   // long rsp back-pressure stretch
   localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on any channel
   localparam int DRAIN       = 20;    // settling wait after the last rsp word
   localparam int PHASE_WORDS = 150;

   // one req word, before packing
   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
      logic [VAL_W-1:0] cx;
      logic [VAL_W-1:0] cy;
      logic [VAL_W-1:0] cz;
   } grid_item_type;

   // one rsp word
   typedef struct packed {
      logic [VAL_W-1:0] curl_x;
      logic [VAL_W-1:0] curl_y;
      logic [VAL_W-1:0] curl_z;
      logic [VAL_W-1:0] divergence;
   } curl_div_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   grid_curl_divergence_top #(
      .MAX_X(GRID_N),
      .MAX_Y(GRID_N),
      .MAX_Z(GRID_N)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // stimulus side: words waiting to be offered, plus the planner's view of
   // the grid (sizes in use, which points hold a loaded value)
   grid_item_type    pending_items[$];
   int               planned = 0;
   logic [SIZE_W-1:0] plan_size [0:2];
   bit               loaded_map [0:GRID_DEPTH-1];
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   bit               hold_req = 1'b0;
   bit               hold_ack = 1'b0;
   int               hold_left = 0;

   // predictor side: own copy of the registers and the three field memories
   logic [SIZE_W-1:0]       pred_size [0:2];
   logic [SCL_W-1:0]        pred_scale;
   logic signed [VAL_W-1:0] field_mem [0:2][0:GRID_DEPTH-1];
   curl_div_type            curl_div_due[$];
   int                      mismatches = 0;
   logic                    req_taken = 1'b0;
   int                      quiet_cycles = 0;

   function automatic int grid_addr(input int x, input int y, input int z);
      return (x * GRID_N + y) * GRID_N + z;
   endfunction

   // sizes below 3 act as 3, above the grid as the grid
   function automatic int eff_size(input logic [SIZE_W-1:0] s);
      if (s < MIN_SIZE) return int'(MIN_SIZE);
      if (s > GRID_N) return GRID_N;
      return int'(s);
   endfunction

   function automatic region_type face_of(input int p, input int n);
      if (p == 0) return REG_LOW;
      if (p + 1 >= n) return REG_HIGH;
      return REG_MID;
   endfunction

   // coordinate of stencil tap k along one axis
   function automatic int stencil_pos(input int p, input int n, input int k);
      case (face_of(p, n))
         REG_LOW:  return k;
         REG_HIGH: return n - 1 - k;
         default:  return (k == TAP_0) ? p + 1 : (k == TAP_1) ? p - 1 : p;
      endcase
   endfunction

   // D * 1/(2h) / 2^16, rounded half away from zero
   function automatic longint scale_diff(input longint d);
      logic [63:0] m;
      logic [63:0] q;
      m = (d < 0) ? 64'(-d) : 64'(d);
      q = m * 64'(pred_scale[31:16]) + ((m * 64'(pred_scale[15:0]) + 64'h8000) >> 16);
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [VAL_W-1:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // scaled partial derivative of one component along one axis
   function automatic longint axis_slope(input int comp, input int px, input int py,
                                         input int pz, input int axis, input int n);
      int         q [0:2];
      longint     v [0:2];
      longint     d;
      int         p;
      int         k;
      region_type face;
      p = (axis == AXIS_X) ? px : (axis == AXIS_Y) ? py : pz;
      face = face_of(p, n);
      for (k = 0; k < 3; k++) begin
         q[0] = px;
         q[1] = py;
         q[2] = pz;
         q[axis] = stencil_pos(p, n, k);
         v[k] = longint'(field_mem[comp][grid_addr(q[0], q[1], q[2])]);
      end
      case (face)
         REG_LOW:  d = 4 * v[1] - 3 * v[0] - v[2];
         REG_HIGH: d = 3 * v[0] - 4 * v[1] + v[2];
         default:  d = v[0] - v[1];
      endcase
      return scale_diff(d);
   endfunction

   function automatic curl_div_type predict_curl_div(input int x, input int y, input int z);
      int           n [0:2];
      int           p [0:2];
      longint       g [0:8];   // component * 3 + axis
      int           c;
      int           a;
      curl_div_type r;
      for (a = 0; a < 3; a++) n[a] = eff_size(pred_size[a]);
      // query coordinates past the sizes in use stick to the last point
      p[0] = (x >= n[0]) ? n[0] - 1 : x;
      p[1] = (y >= n[1]) ? n[1] - 1 : y;
      p[2] = (z >= n[2]) ? n[2] - 1 : z;
      for (c = 0; c < 3; c++)
         for (a = 0; a < 3; a++)
            g[c * 3 + a] = axis_slope(c, p[0], p[1], p[2], a, n[a]);
      r.curl_x     = clip32(g[2 * 3 + AXIS_Y] - g[1 * 3 + AXIS_Z]);
      r.curl_y     = clip32(g[0 * 3 + AXIS_Z] - g[2 * 3 + AXIS_X]);
      r.curl_z     = clip32(g[1 * 3 + AXIS_X] - g[0 * 3 + AXIS_Y]);
      r.divergence = clip32(g[0 * 3 + AXIS_X] + g[1 * 3 + AXIS_Y] + g[2 * 3 + AXIS_Z]);
      return r;
   endfunction

   // component values: rail values, zero, -1, small magnitudes, anything
   function automatic logic [VAL_W-1:0] pick_component(input bit extreme);
      logic [VAL_W-1:0] r;
      r = $urandom;
      case (extreme ? $urandom_range(1) : $urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0;
         3:       return 32'hFFFF_FFFF;
         4:       return {{14{r[17]}}, r[17:0]};
         default: return r;
      endcase
   endfunction

   // lean toward the faces and the points next to them
   function automatic int pick_coord(input int n);
      case ($urandom_range(5))
         0:       return 0;
         1:       return 1;
         2:       return n - 2;
         3:       return n - 1;
         default: return $urandom_range(GRID_N - 1);
      endcase
   endfunction

   task automatic queue_item(input logic kind, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                             input logic [VAL_W-1:0] cx, input logic [VAL_W-1:0] cy,
                             input logic [VAL_W-1:0] cz);
      grid_item_type it;
      it.kind = kind;
      it.x = x;
      it.y = y;
      it.z = z;
      it.cx = cx;
      it.cy = cy;
      it.cz = cz;
      pending_items = {pending_items, it};
      planned++;
   endtask

   // A query plus the loads it needs first: every stencil point it reads is
   // loaded before it, so no never-written entry is ever read. Points already
   // holding a value are reloaded now and then with fresh data.
   task automatic add_query(input int x, input int y, input int z,
                            input int rewrite_pct, input bit extreme);
      int n [0:2];
      int c [0:2];
      int q [0:2];
      int a;
      int k;
      int at;
      for (a = 0; a < 3; a++) n[a] = eff_size(plan_size[a]);
      c[0] = (x >= n[0]) ? n[0] - 1 : x;
      c[1] = (y >= n[1]) ? n[1] - 1 : y;
      c[2] = (z >= n[2]) ? n[2] - 1 : z;
      for (a = 0; a < 3; a++) begin
         for (k = 0; k < 3; k++) begin
            q[0] = c[0];
            q[1] = c[1];
            q[2] = c[2];
            q[a] = stencil_pos(c[a], n[a], k);
            at = grid_addr(q[0], q[1], q[2]);
            if (!loaded_map[at] || $urandom_range(99) < rewrite_pct) begin
               loaded_map[at] = 1'b1;
               queue_item(KIND_LOAD, POS_W'(q[0]), POS_W'(q[1]), POS_W'(q[2]),
                          pick_component(extreme), pick_component(extreme),
                          pick_component(extreme));
            end
         end
      end
      // component fields of a query are don't-care: fill with noise
      queue_item(KIND_QUERY, POS_W'(x), POS_W'(y), POS_W'(z), $urandom, $urandom, $urandom);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_grid(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                               input logic [SIZE_W-1:0] sz, input logic [SCL_W-1:0] k);
      write_csr(CSR_SIZE_X, CSR_DATA_W'(sx));
      write_csr(CSR_SIZE_Y, CSR_DATA_W'(sy));
      write_csr(CSR_SIZE_Z, CSR_DATA_W'(sz));
      write_csr(CSR_INV_TWO_H, k);
      plan_size[0] = sx;
      plan_size[1] = sy;
      plan_size[2] = sz;
   endtask

   // wait for the block to go quiet: nothing left to send, nothing owed back.
   // Checked on the rising edge, where valid and the queues are stable.
   task automatic settle();
      @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || curl_div_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic check_word(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // req driver: holds a word until taken, may idle before the next one
   always @(negedge clock) begin : drive_req
      grid_item_type         it;
      logic [REQ_DATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            word = '0;
            word[POS_X_LSB +: POS_W] = it.x;
            word[POS_Y_LSB +: POS_W] = it.y;
            word[POS_Z_LSB +: POS_W] = it.z;
            word[COMP_X_LSB +: VAL_W] = it.cx;
            word[COMP_Y_LSB +: VAL_W] = it.cy;
            word[COMP_Z_LSB +: VAL_W] = it.cz;
            req_tdata <= word;
            req_tuser <= it.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp back-pressure: random stalls, or one long hold when asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor and predictor: all three channels sampled on the rising edge
   always @(posedge clock) begin : watch_ports
      curl_div_type got;
      curl_div_type want;
      curl_div_type due;
      int           at;
      if (reset) begin
         req_taken <= 1'b0;
         pred_size[0] = SIZE_RESET;
         pred_size[1] = SIZE_RESET;
         pred_size[2] = SIZE_RESET;
         pred_scale = INV_TWO_H_RESET;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIZE_X:    pred_size[0] = csr_data[SIZE_W-1:0];
               CSR_SIZE_Y:    pred_size[1] = csr_data[SIZE_W-1:0];
               CSR_SIZE_Z:    pred_size[2] = csr_data[SIZE_W-1:0];
               CSR_INV_TWO_H: pred_scale = csr_data[SCL_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == KIND_LOAD) begin
               at = grid_addr(int'(req_tdata[POS_X_LSB +: POS_W]),
                              int'(req_tdata[POS_Y_LSB +: POS_W]),
                              int'(req_tdata[POS_Z_LSB +: POS_W]));
               field_mem[0][at] = req_tdata[COMP_X_LSB +: VAL_W];
               field_mem[1][at] = req_tdata[COMP_Y_LSB +: VAL_W];
               field_mem[2][at] = req_tdata[COMP_Z_LSB +: VAL_W];
            end else begin
               due = predict_curl_div(int'(req_tdata[POS_X_LSB +: POS_W]),
                                      int'(req_tdata[POS_Y_LSB +: POS_W]),
                                      int'(req_tdata[POS_Z_LSB +: POS_W]));
               curl_div_due = {curl_div_due, due};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.curl_x     = rsp_tdata[RES_CURL_X * VAL_W +: VAL_W];
            got.curl_y     = rsp_tdata[RES_CURL_Y * VAL_W +: VAL_W];
            got.curl_z     = rsp_tdata[RES_CURL_Z * VAL_W +: VAL_W];
            got.divergence = rsp_tdata[RES_DIV * VAL_W +: VAL_W];
            if (curl_div_due.size() == 0) begin
               mismatches++;
               $display("%0t ns: rsp word with no query pending, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = curl_div_due.pop_front();
               check_word("curl_x", want.curl_x, got.curl_x);
               check_word("curl_y", want.curl_y, got.curl_y);
               check_word("curl_z", want.curl_z, got.curl_z);
               check_word("divergence", want.divergence, got.divergence);
            end
         end
      end
   end

   // watchdog: too long with no word moving anywhere means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_phases
      int                phase;
      int                goal;
      int                n [0:2];
      logic [SIZE_W-1:0] sz [0:2];
      int                a;
      for (a = 0; a < GRID_DEPTH; a++) loaded_map[a] = 1'b0;
      plan_size[0] = SIZE_RESET;
      plan_size[1] = SIZE_RESET;
      plan_size[2] = SIZE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset registers, full 16^3 grid, no idling. Low-face
      // corner, high-face corner and an interior point, each stencil loaded
      // with rail values so the sums can saturate.
      add_query(0, 0, 0, 0, 1'b1);
      add_query(GRID_N - 1, GRID_N - 1, GRID_N - 1, 0, 1'b1);
      add_query(7, 8, 9, 0, 1'b1);
      settle();

      for (phase = 1; phase <= 9; phase++) begin
         case (phase)
            1: program_grid(MIN_SIZE, MIN_SIZE, MIN_SIZE, 32'hFFFF_FFFF); // tiny grid, max scale
            2: program_grid(5'd0, 5'd1, 5'd2, 32'd1);      // undersized, smallest scale
            3: program_grid(5'd31, 5'd17, 5'd16, 32'd0);   // oversized, zero scale
            default: begin
               for (a = 0; a < 3; a++)
                  sz[a] = SIZE_W'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                            : $urandom_range(3, 16));
               case ($urandom_range(4))
                  0:       program_grid(sz[0], sz[1], sz[2], 32'd1);
                  1:       program_grid(sz[0], sz[1], sz[2], 32'hFFFF_FFFF);
                  2:       program_grid(sz[0], sz[1], sz[2], $urandom);
                  3:       program_grid(sz[0], sz[1], sz[2], $urandom_range(32'h3FFFF));
                  default: program_grid(sz[0], sz[1], sz[2], 32'h0001_0000);
               endcase
            end
         endcase
         @(posedge clock);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         // one long rsp hold while req keeps offering: queries pile up and
         // the block has to stall req
         if (phase == 4) hold_req = !hold_req;
         for (a = 0; a < 3; a++) n[a] = eff_size(plan_size[a]);
         goal = planned + PHASE_WORDS;
         while (planned < goal) begin
            if ($urandom_range(99) < 15)
               // stray load anywhere in the memory, inside the sizes or not
               queue_item(KIND_LOAD, POS_W'($urandom_range(GRID_N - 1)),
                          POS_W'($urandom_range(GRID_N - 1)),
                          POS_W'($urandom_range(GRID_N - 1)), pick_component(1'b0),
                          pick_component(1'b0), pick_component(1'b0));
            else
               add_query(pick_coord(n[0]), pick_coord(n[1]), pick_coord(n[2]), 20, 1'b0);
         end
         settle();
      end

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/gcd_pkg.sv
hdl/grid_curl_divergence_top.sv
tb/sv/grid_curl_divergence_top_tb.sv
